/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL of the cluster lookup block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property holds at every clock edge outside reset.
`define FNC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition never holds at a clock edge outside reset.
`define FNC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FNC_ASSERT(label, clk, rst_n, prop, msg)
`define FNC_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

/* rtl/core/fnc_pkg.sv */
`default_nettype none

package fnc_pkg;

  localparam int OFF_W = 30;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_OPEN   = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;

  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;

  localparam logic CFG_FAT_KIND = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  localparam logic [11:0] FAT12_MASK = 12'hFFF;
  localparam logic [31:0] FAT12_EOC  = 32'h0000_0FF8;
  localparam logic [31:0] FAT12_EXT  = 32'hFFFF_F000;
  localparam logic [31:0] FAT16_EOC  = 32'h0000_FFF8;
  localparam logic [31:0] FAT16_EXT  = 32'hFFFF_0000;

  typedef struct packed {
    logic [1:0] kind;
    logic       odd;
    logic [1:0] lane;
  } fnc_dec_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/fnc_window_ram.sv */
`default_nettype none

module fnc_window_ram #(
  parameter int WORDS = 512,
  parameter int AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [1:0]    wlane,
  input  wire logic [7:0]    wbyte,
  input  wire logic [AW-1:0] raddr0,
  input  wire logic [AW-1:0] raddr1,
  output logic      [31:0]   rdata0,
  output logic      [31:0]   rdata1
);

  logic [31:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][{wlane, 3'b000} +: 8] <= wbyte;
    end
  end

  // Reads return the contents from before a write on the same edge.
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

/* rtl/core/fnc_entry_decode.sv */
`default_nettype none

module fnc_entry_decode (
  input  wire fnc_pkg::fnc_dec_ctl_t ctl,
  input  wire logic [31:0]           word0,
  input  wire logic [31:0]           word1,
  output logic      [31:0]           entry
);

  import fnc_pkg::*;

  logic [63:0] pair;
  logic [31:0] raw;
  logic [31:0] e12;
  logic [31:0] e16;

  assign pair = {word1, word0};
  assign raw  = 32'(pair >> {ctl.lane, 3'b000});
  assign e16  = {16'h0000, raw[15:0]};

  // The odd cluster of a FAT12 pair lives in the upper twelve bits.
  assign e12 = ctl.odd ? {20'h00000, raw[15:4]} : {20'h00000, raw[11:0] & FAT12_MASK};

  always_comb begin
    case (ctl.kind)
      KIND_FAT12: entry = (e12 >= FAT12_EOC) ? (e12 | FAT12_EXT) : e12;
      KIND_FAT16: entry = (e16 >= FAT16_EOC) ? (e16 | FAT16_EXT) : e16;
      default:    entry = raw;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/fat_next_cluster_lookup.sv */
// The result passes the offset register, the byte-store read and the decode register, and
// out_valid strobes for a single cycle per result. Throughput: one item per cycle; busy
// stays low.
// Reset clears the pipeline, the window (none held) and the registers to FAT16 with one
// reserved sector. The byte store has no reset and is not cleared.
`default_nettype none
`include "assert_macros.svh"

module fat_next_cluster_lookup #(
  parameter int WINDOW_SECTORS = 4,
  parameter int SECTOR_BYTES   = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [27:0] in_cluster,
  input  wire logic [20:0] in_window_sector,
  input  wire logic [10:0] in_fill_offset,
  input  wire logic [7:0]  in_fill_byte,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_next_cluster,
  output logic [21:0]      out_fetch_sector,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  import fnc_pkg::*;

  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int WIN_BYTES    = WINDOW_SECTORS * SECTOR_BYTES;
  localparam int WS_W         = $clog2(WINDOW_SECTORS);
  localparam int REL_W        = WS_W + SECTOR_SHIFT;
  localparam int WORDS        = WIN_BYTES / 4;
  localparam int ROW_W        = REL_W - 2;
  localparam int SEC_W        = OFF_W - SECTOR_SHIFT;

  logic              accept;
  logic [1:0]        fat_kind_r;
  logic [15:0]       reserved_r;
  logic [20:0]       window_start_r;
  logic              win_valid_r;

  logic              s1_valid_r;
  logic [1:0]        s1_op_r;
  logic              s1_odd_r;
  logic [OFF_W-1:0]  s1_offset_r;
  logic [OFF_W-1:0]  offset_nxt;

  logic [SEC_W-1:0]  sector;
  logic [31:0]       sec32;
  logic [31:0]       ws32;
  logic [31:0]       sec_diff;
  logic [REL_W-1:0]  rel;
  logic [2:0]        ent_bytes;
  logic              in_win;
  logic              fits;
  logic              s1_hit;
  logic [ROW_W-1:0]  row0;
  logic [ROW_W-1:0]  row1;

  logic              s2_valid_r;
  logic [1:0]        s2_status_r;
  logic [1:0]        s2_status_nxt;
  logic [21:0]       s2_fetch_r;
  logic [21:0]       s2_fetch_nxt;
  fnc_dec_ctl_t      s2_ctl_r;

  logic [31:0]       foff32;
  logic              mem_we;
  logic [31:0]       rdata0;
  logic [31:0]       rdata1;
  logic [31:0]       entry;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [31:0]       out_next_cluster_r;
  logic [31:0]       out_next_cluster_nxt;
  logic [21:0]       out_fetch_sector_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat_kind_r <= KIND_FAT16;
      reserved_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FAT_KIND: fat_kind_r <= cfg_data[1:0];
        CFG_RESERVED: reserved_r <= cfg_data;
        default:      fat_kind_r <= fat_kind_r;
      endcase
    end
  end

  // Byte offset of the table entry; FAT12 packs two entries in three bytes.
  always_comb begin
    case (fat_kind_r)
      KIND_FAT12: offset_nxt = OFF_W'(({2'b00, in_cluster} + {1'b0, in_cluster, 1'b0}) >> 1);
      KIND_FAT16: offset_nxt = OFF_W'({in_cluster, 1'b0});
      default:    offset_nxt = {in_cluster, 2'b00};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_start_r <= '0;
      win_valid_r    <= 1'b0;
    end else if (accept && in_opcode == OP_OPEN) begin
      window_start_r <= in_window_sector;
      win_valid_r    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r     <= in_opcode;
      s1_odd_r    <= in_cluster[0];
      s1_offset_r <= offset_nxt;
    end
  end

  // Fill writes go straight into the store at the accepting edge. A lookup reads the store at
  // the edge after its own acceptance, so it sees every earlier fill and none that follows it.
  assign foff32 = 32'(in_fill_offset);
  assign mem_we = accept && in_opcode == OP_WRITE && foff32 < 32'(WIN_BYTES);

  assign sector   = s1_offset_r[OFF_W-1:SECTOR_SHIFT];
  assign sec32    = 32'(sector);
  assign ws32     = 32'(window_start_r);
  assign sec_diff = sec32 - ws32;
  assign rel      = {sec_diff[WS_W-1:0], s1_offset_r[SECTOR_SHIFT-1:0]};
  assign in_win   = win_valid_r && sec32 >= ws32 && sec32 < ws32 + 32'(WINDOW_SECTORS);

  always_comb begin
    case (fat_kind_r)
      KIND_FAT12: ent_bytes = 3'd2;
      KIND_FAT16: ent_bytes = 3'd2;
      default:    ent_bytes = 3'd4;
    endcase
  end

  // An entry that runs past the window end is treated as not held.
  assign fits   = (32'(rel) + 32'(ent_bytes)) <= 32'(WIN_BYTES);
  assign s1_hit = in_win && fits;

  assign row0 = rel[REL_W-1:2];
  assign row1 = (row0 == ROW_W'(WORDS - 1)) ? '0 : row0 + ROW_W'(1);

  fnc_window_ram #(
    .WORDS (WORDS),
    .AW    (ROW_W)
  ) u_ram (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (foff32[REL_W-1:2]),
    .wlane  (in_fill_offset[1:0]),
    .wbyte  (in_fill_byte),
    .raddr0 (row0),
    .raddr1 (row1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  always_comb begin
    s2_fetch_nxt = '0;
    if (s1_op_r == OP_LOOKUP) begin
      if (s1_hit) begin
        s2_status_nxt = ST_HIT;
      end else begin
        s2_status_nxt = ST_MISS;
        s2_fetch_nxt  = 22'(32'(reserved_r) + sec32);
      end
    end else begin
      s2_status_nxt = ST_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_status_r   <= s2_status_nxt;
    s2_fetch_r    <= s2_fetch_nxt;
    s2_ctl_r.kind <= fat_kind_r;
    s2_ctl_r.odd  <= s1_odd_r;
    s2_ctl_r.lane <= rel[1:0];
  end

  fnc_entry_decode u_decode (
    .ctl   (s2_ctl_r),
    .word0 (rdata0),
    .word1 (rdata1),
    .entry (entry)
  );

  assign out_next_cluster_nxt = (s2_status_r == ST_HIT) ? entry : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r       <= s2_status_r;
    out_next_cluster_r <= out_next_cluster_nxt;
    out_fetch_sector_r <= s2_fetch_r;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_next_cluster = out_next_cluster_r;
  assign out_fetch_sector = out_fetch_sector_r;

  `FNC_ASSERT(a_result_follows_beat, clk, rst_n, out_valid_r |-> $past(start && !busy, 3), "result without an accepted beat")
  `FNC_ASSERT_NEVER(a_hit_needs_window, clk, rst_n, out_valid_r && out_status_r == ST_HIT && !$past(win_valid_r, 2), "hit reported with no window held")
  `FNC_ASSERT(a_entry_only_on_hit, clk, rst_n, (out_valid_r && out_status_r != ST_HIT) |-> (out_next_cluster_r == '0), "next cluster driven without a hit")
  `FNC_ASSERT(a_fetch_only_on_miss, clk, rst_n, (out_valid_r && out_status_r != ST_MISS) |-> (out_fetch_sector_r == '0), "fetch sector driven without a miss")

endmodule

`default_nettype wire

/* tb/fat_next_cluster_lookup_checker.sv */
`timescale 1ns / 1ps

module fat_next_cluster_lookup_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [27:0] in_cluster,
  input  logic [20:0] in_window_sector,
  input  logic [10:0] in_fill_offset,
  input  logic [7:0]  in_fill_byte,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_next_cluster,
  input  logic [21:0] out_fetch_sector,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned errors,
  output int unsigned outstanding
);
  import fnc_pkg::*;

  localparam int unsigned SECTOR_BYTES   = 512;
  localparam int unsigned WINDOW_SECTORS = 4;
  localparam int unsigned WIN_BYTES      = SECTOR_BYTES * WINDOW_SECTORS;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_cluster;
    logic [21:0] fetch_sector;
  } link_t;

  localparam link_t FILL_DONE = '{status: ST_FILL, next_cluster: 32'd0, fetch_sector: 22'd0};

  link_t       awaited_links [$];
  logic [1:0]  kind;
  logic [15:0] reserved;
  logic [7:0]  fat_bytes [WIN_BYTES];
  logic [20:0] win_base;
  logic        win_held;

  function automatic link_t next_link(input logic [27:0] cluster);
    logic [31:0] off;
    logic [31:0] sector;
    logic [31:0] rel;
    logic [31:0] entry;
    logic [31:0] sum;
    int unsigned width;
    link_t       res;
    case (kind)
      KIND_FAT12: begin
        off = ({4'd0, cluster} * 32'd3) >> 1;
        width = 2;
      end
      KIND_FAT16: begin
        off = {3'd0, cluster, 1'b0};
        width = 2;
      end
      // FAT32, and the spare code, which decodes the same way.
      default: begin
        off = {2'd0, cluster, 2'd0};
        width = 4;
      end
    endcase
    sector = off / SECTOR_BYTES;
    rel = off - {11'd0, win_base} * SECTOR_BYTES;
    // The whole entry has to sit inside the window; one that runs past its end misses.
    if (win_held && sector >= {11'd0, win_base} &&
        sector < {11'd0, win_base} + WINDOW_SECTORS && rel + width <= WIN_BYTES) begin
      entry = {16'd0, fat_bytes[rel + 1], fat_bytes[rel]};
      case (kind)
        KIND_FAT12: begin
          // Odd clusters own the upper twelve bits of the pair, even ones the lower.
          entry = cluster[0] ? entry >> 4 : entry & {20'd0, FAT12_MASK};
          if (entry >= FAT12_EOC) entry = entry | FAT12_EXT;
        end
        KIND_FAT16: begin
          if (entry >= FAT16_EOC) entry = entry | FAT16_EXT;
        end
        default: begin
          entry[31:16] = {fat_bytes[rel + 3], fat_bytes[rel + 2]};
        end
      endcase
      res = '{status: ST_HIT, next_cluster: entry, fetch_sector: 22'd0};
    end else begin
      sum = {16'd0, reserved} + sector;
      res = '{status: ST_MISS, next_cluster: 32'd0, fetch_sector: sum[21:0]};
    end
    return res;
  endfunction

  always @(posedge clk) begin
    link_t want;
    if (!rst_n) begin
      kind = KIND_FAT16;
      reserved = 16'd1;
      win_base = '0;
      win_held = 1'b0;
      awaited_links.delete();
    end else begin
      if (out_valid) begin
        if (awaited_links.size() == 0) begin
          $error("result beat with nothing outstanding: status %0d next_cluster %h fetch_sector %h",
                 out_status, out_next_cluster, out_fetch_sector);
          errors++;
        end else begin
          want = awaited_links.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_next_cluster !== want.next_cluster) begin
            $error("next_cluster: expected %h, got %h", want.next_cluster, out_next_cluster);
            errors++;
          end
          if (out_fetch_sector !== want.fetch_sector) begin
            $error("fetch_sector: expected %h, got %h", want.fetch_sector, out_fetch_sector);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FAT_KIND) kind = cfg_data[1:0];
        else reserved = cfg_data;
      end
      if (start && !busy) begin
        case (in_opcode)
          OP_LOOKUP: awaited_links.push_back(next_link(in_cluster));
          OP_OPEN: begin
            // Opening moves the window only; the stored bytes stay as they were.
            win_base = in_window_sector;
            win_held = 1'b1;
            awaited_links.push_back(FILL_DONE);
          end
          OP_WRITE: begin
            fat_bytes[in_fill_offset] = in_fill_byte;
            awaited_links.push_back(FILL_DONE);
          end
          default: awaited_links.push_back(FILL_DONE);
        endcase
      end
    end
    outstanding = awaited_links.size();
  end

endmodule

/* tb/fat_next_cluster_lookup_test.sv */
`timescale 1ns / 1ps

module fat_next_cluster_lookup_test;
  import fnc_pkg::*;

  localparam logic [1:0] OP_NONE    = 2'd3;
  localparam logic [1:0] KIND_FAT32 = 2'd2;
  localparam logic [1:0] KIND_WIDE  = 2'd3;
  localparam int WIN_BYTES      = 2048;
  localparam int WINDOW_SECTORS = 4;
  localparam int LATENCY        = 3;
  localparam int STALL_LIMIT    = 2000;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 110;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = OP_LOOKUP;
  logic [27:0] in_cluster = '0;
  logic [20:0] in_window_sector = '0;
  logic [10:0] in_fill_offset = '0;
  logic [7:0]  in_fill_byte = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_next_cluster;
  logic [21:0] out_fetch_sector;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_FAT_KIND;
  logic [15:0] cfg_data = '0;
  int unsigned errors;
  int unsigned outstanding;

  // What the sender knows of the block, so that it never reads a byte it has not written.
  logic [1:0]  cur_kind = KIND_FAT16;
  logic [20:0] win_base = '0;
  logic        win_held = 1'b0;
  bit          byte_set [WIN_BYTES];
  bit          gaps_on = 1'b0;
  int unsigned issued = 0;
  int unsigned stall = 0;
  logic [1:0]  phase_kind [PHASES] = '{KIND_FAT12, KIND_FAT16, KIND_FAT32, KIND_WIDE,
                                       KIND_FAT12, KIND_FAT16, KIND_FAT32};

  always #5 clk = ~clk;

  fat_next_cluster_lookup DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_opcode(in_opcode),
    .in_cluster(in_cluster),
    .in_window_sector(in_window_sector),
    .in_fill_offset(in_fill_offset),
    .in_fill_byte(in_fill_byte),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_next_cluster(out_next_cluster),
    .out_fetch_sector(out_fetch_sector),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  fat_next_cluster_lookup_checker chain_check (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_opcode(in_opcode),
    .in_cluster(in_cluster),
    .in_window_sector(in_window_sector),
    .in_fill_offset(in_fill_offset),
    .in_fill_byte(in_fill_byte),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_next_cluster(out_next_cluster),
    .out_fetch_sector(out_fetch_sector),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall <= 0;
    end else if (stall == STALL_LIMIT) begin
      $display("fat_next_cluster_lookup_test: errors");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  function automatic logic [31:0] entry_offset(input logic [27:0] c);
    case (cur_kind)
      KIND_FAT12: return ({4'd0, c} * 32'd3) >> 1;
      KIND_FAT16: return {3'd0, c, 1'b0};
      default:    return {2'd0, c, 2'd0};
    endcase
  endfunction

  function automatic int entry_width();
    return (cur_kind == KIND_FAT12 || cur_kind == KIND_FAT16) ? 2 : 4;
  endfunction

  // Position of the entry inside the held window, or -1 when the lookup would miss.
  function automatic int held_rel(input logic [27:0] c);
    logic [31:0] off;
    logic [31:0] sector;
    logic [31:0] rel;
    off = entry_offset(c);
    sector = off >> 9;
    rel = off - {2'd0, win_base, 9'd0};
    if (win_held && sector >= {11'd0, win_base} &&
        sector < {11'd0, win_base} + WINDOW_SECTORS && rel + entry_width() <= WIN_BYTES)
      return int'(rel);
    return -1;
  endfunction

  // Table bytes lean towards all ones so that end-of-chain marks turn up often.
  function automatic logic [7:0] fat_byte();
    return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
  endfunction

  function automatic logic [27:0] pick_cluster();
    logic [5:0] m;
    m = 6'($urandom);
    case ($urandom_range(0, 3))
      0: return 28'($urandom);
      // Clusters whose entry ends a sector, so that it can end the window or run past it.
      1: begin
        case (cur_kind)
          KIND_FAT12: return {12'd0, m, 10'd341};
          KIND_FAT16: return {14'd0, m, 8'd255};
          default:    return {15'd0, m, 7'd127};
        endcase
      end
      default: return 28'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic issue(input logic [1:0] op, input logic [27:0] c, input logic [20:0] ws,
                       input logic [10:0] off, input logic [7:0] val);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_cluster <= c;
    in_window_sector <= ws;
    in_fill_offset <= off;
    in_fill_byte <= val;
    do @(posedge clk); while (busy !== 1'b0);
    issued++;
    case (op)
      OP_OPEN: begin
        win_base = ws;
        win_held = 1'b1;
      end
      OP_WRITE: byte_set[off] = 1'b1;
      default: ;
    endcase
  endtask

  task automatic put_byte(input logic [10:0] off, input logic [7:0] val);
    issue(OP_WRITE, 28'($urandom), 21'($urandom), off, val);
  endtask

  task automatic open_at(input logic [20:0] sec);
    issue(OP_OPEN, 28'($urandom), sec, 11'($urandom), 8'($urandom));
  endtask

  // A lookup that would hit bytes never written gets them written first.
  task automatic look(input logic [27:0] c);
    int rel;
    rel = held_rel(c);
    if (rel >= 0) begin
      for (int i = 0; i < entry_width(); i++)
        if (!byte_set[rel + i]) put_byte(11'(rel + i), fat_byte());
    end
    issue(OP_LOOKUP, c, 21'($urandom), 11'($urandom), 8'($urandom));
  endtask

  // Miss, load the window the way software would, then retry.
  task automatic chain_step();
    logic [27:0] c;
    logic [31:0] off;
    logic [31:0] rel;
    logic [20:0] sec;
    logic [20:0] back;
    c = pick_cluster();
    look(c);
    if (held_rel(c) < 0 && $urandom_range(0, 3) != 0) begin
      off = entry_offset(c);
      sec = off[29:9];
      back = 21'($urandom_range(0, WINDOW_SECTORS - 1));
      if (back > sec) back = sec;
      open_at(sec - back);
      rel = off - {2'd0, win_base, 9'd0};
      for (int i = 0; i < entry_width(); i++)
        if (rel + i < WIN_BYTES) put_byte(11'(rel + i), fat_byte());
      repeat ($urandom_range(0, 2)) put_byte(11'($urandom), 8'($urandom));
      look(c);
    end
  endtask

  task automatic noise();
    case ($urandom_range(0, 3))
      0: issue(OP_NONE, 28'($urandom), 21'($urandom), 11'($urandom), 8'($urandom));
      1: put_byte(11'($urandom), 8'($urandom));
      2: open_at(21'($urandom));
      default: look(28'($urandom));
    endcase
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == CFG_FAT_KIND) cur_kind = data[1:0];
  endtask

  initial begin
    int unsigned target;
    int unsigned next_flip;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // No window is held yet, so both lookups miss whatever the cluster.
    look(28'd0);
    issue(OP_NONE, 28'($urandom), 21'($urandom), 11'($urandom), 8'($urandom));
    look(28'hFFF_FFFF);

    write_reg(CFG_RESERVED, 16'hFFFF);
    write_reg(CFG_FAT_KIND, {14'($urandom), KIND_FAT12});
    open_at(21'd0);
    put_byte(11'd3, 8'hF8);
    put_byte(11'd4, 8'hFF);
    put_byte(11'd5, 8'h7F);
    look(28'd2);
    look(28'd3);
    // This entry starts on the last byte of the window.
    look(28'd1365);
    open_at(21'h1F_FFFF);
    look(28'd2);
    open_at(21'd0);
    look(28'd2);

    write_reg(CFG_FAT_KIND, {14'($urandom), KIND_FAT32});
    for (int i = 8; i < 12; i++) put_byte(11'(i), 8'hFF);
    look(28'd2);
    write_reg(CFG_FAT_KIND, {14'($urandom), KIND_WIDE});
    look(28'd2);
    write_reg(CFG_FAT_KIND, {14'($urandom), KIND_FAT16});
    put_byte(11'd2, 8'hF7);
    put_byte(11'd3, 8'hFF);
    look(28'd1);
    look(28'd4);

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_RESERVED, (p == 0 || p == 5) ? 16'd0 :
                              (p == 1 || p == 6) ? 16'hFFFF : 16'($urandom));
      write_reg(CFG_FAT_KIND, {14'($urandom), phase_kind[p]});
      target = issued + PHASE_ITEMS;
      next_flip = issued;
      while (issued < target) begin
        if (issued >= next_flip) begin
          gaps_on = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
          next_flip = issued + 40;
        end
        if ($urandom_range(0, 4) == 0) noise();
        else chain_step();
      end
    end

    settle();
    if (errors == 0 && outstanding == 0)
      $display("fat_next_cluster_lookup_test: clean");
    else
      $display("fat_next_cluster_lookup_test: errors");
    $finish;
  end

endmodule
